// File: rtl/stb_pkg.sv
// Shared types and constants for the one-shot timer bank.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stb_pkg;

   localparam int CMD_W  = 2;
   localparam int IDX_W  = 8;
   localparam int DUR_W  = 32;
   localparam int TICK_W = 31;

   // Largest tick count a timer is loaded with.
   localparam logic [TICK_W-1:0] TICK_LIMIT = {1'b1, 30'd0};

   // Expiries reported per tick request; further expiries still idle their timers.
   localparam int MAX_RESULTS = 8;
   localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int FIRE_PTR_W  = $clog2(MAX_RESULTS);

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_TICK  = 2'd3
   } command_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic div_step;
      logic load;
      logic respond;
      logic walk;
      logic tick_finish;
      logic emit;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic req_is_tick;
      logic req_is_load;
      logic div_done;
      logic walk_done;
      logic emit_last;
   } ctrl_status_type;

endpackage

// File: rtl/stb_ctrl.sv
// Sequencing state machine of the timer bank.
// Depends on stb_pkg for the command and status structs.
`timescale 1ns / 1ps

module stb_ctrl
   import stb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_LOAD = 6'b000100,
      S_RESP = 6'b001000,
      S_WALK = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (status.req_is_tick) begin
                  state_in = S_WALK;
               end else if (status.req_is_load) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               cmd.tick_finish = 1'b1;
               state_in        = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/stb_datapath.sv
// Datapath of the timer bank: count store, running flags, tick divider,
// expiry list and result register. Depends on stb_pkg.
`timescale 1ns / 1ps

module stb_datapath
   import stb_pkg::*;
#(
   parameter int NUM_TIMERS  = 8,
   parameter int MS_PER_TICK = 1
)(
   input  logic               clock,
   input  logic               reset,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [IDX_W-1:0]   req_timer_index,
   input  logic [DUR_W-1:0]   req_duration_ms,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   output logic               rsp_valid,
   output logic [IDX_W-1:0]   rsp_result_index,
   output logic               rsp_expired,
   output logic               rsp_running,
   output logic               rsp_any_active,
   output logic               rsp_last
);

   localparam int  IW       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int  CW       = $clog2(NUM_TIMERS + 1);
   localparam bit  DIV_POW2 = ((MS_PER_TICK & (MS_PER_TICK - 1)) == 0);
   localparam int  SHIFT    = $clog2(MS_PER_TICK);

   // Captured request
   command_type        cmd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [DUR_W-1:0]   ms_ff;
   logic               idx_ok_ff;
   logic               idx_ok;

   // Timer state
   logic [TICK_W-1:0]     rem_mem [NUM_TIMERS];
   logic [TICK_W-1:0]     rem_q_ff;
   logic [NUM_TIMERS-1:0] run_ff;
   logic [NUM_TIMERS-1:0] run_in;
   logic                  tick_en_ff;

   // Walk pipeline
   logic [CW-1:0]  rd_ptr_ff;
   logic           p1_vld_ff;
   logic [IW-1:0]  p1_idx_ff;
   logic           any_acc_ff;
   logic           rd_more;
   logic [TICK_W-1:0] dec;
   logic           p1_run;
   logic           fire;

   // Expiry list
   logic [IDX_W-1:0]      fire_list_ff [MAX_RESULTS];
   logic [FIRE_CNT_W-1:0] fire_cnt_ff;
   logic [FIRE_CNT_W-1:0] emit_ptr_ff;

   // Count store write port
   logic              mem_we;
   logic [IW-1:0]     mem_addr;
   logic [TICK_W-1:0] mem_data;

   // Tick count
   logic [DUR_W:0]    ticks_full;
   logic [TICK_W-1:0] ticks_sat;
   logic              div_done;

   // Result register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic              rsp_expired_ff;
   logic              rsp_running_ff;
   logic              rsp_active_ff;
   logic              rsp_last_ff;

   assign idx_ok = ({1'b0, req_timer_index} < (IDX_W + 1)'(NUM_TIMERS));

   assign status.req_is_tick = (command_type'(req_command) == CMD_TICK);
   assign status.req_is_load = (command_type'(req_command) == CMD_START) && idx_ok
                               && (req_duration_ms != '0);
   assign status.div_done    = div_done;
   assign status.walk_done   = !rd_more && !p1_vld_ff;
   assign status.emit_last   = (fire_cnt_ff == '0)
                               || (emit_ptr_ff == (fire_cnt_ff - FIRE_CNT_W'(1)));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= command_type'(req_command);
         idx_ff    <= req_timer_index;
         ms_ff     <= req_duration_ms;
         idx_ok_ff <= idx_ok;
      end
   end

   // Duration to ticks, rounded up
   generate
      if (DIV_POW2) begin : g_shift
         logic [DUR_W:0] num_w;
         assign num_w      = {1'b0, ms_ff} + (DUR_W + 1)'(MS_PER_TICK - 1);
         assign ticks_full = num_w >> SHIFT;
         assign div_done   = 1'b1;
      end else begin : g_div
         // Floor division by the rounded-up reciprocal of MS_PER_TICK, exact for
         // any 33-bit dividend; apply its low and high halves on successive cycles
         localparam int              NUM_W  = DUR_W + 1;
         localparam int              HALF   = (NUM_W + 1) / 2;
         localparam int              PROD_W = NUM_W + 2 * HALF;
         localparam int              L      = $clog2(MS_PER_TICK);
         localparam logic [63:0]     RCP    = ((64'd1 << (NUM_W + L))
                                              + 64'(MS_PER_TICK - 1)) / 64'(MS_PER_TICK);
         localparam logic [HALF-1:0] RCP_LO = RCP[HALF-1:0];
         localparam logic [HALF-1:0] RCP_HI = RCP[2*HALF-1:HALF];
         logic [NUM_W-1:0]      num_ff;
         logic [HALF-1:0]       rcp_part;
         logic [NUM_W+HALF-1:0] prod;
         logic [PROD_W-1:0]     acc_ff;
         logic [1:0]            step_ff;

         assign rcp_part = (step_ff == 2'd0) ? RCP_LO : RCP_HI;
         assign prod     = (NUM_W + HALF)'(num_ff) * (NUM_W + HALF)'(rcp_part);
         assign div_done = (step_ff == 2'd2);

         always_ff @(posedge clock) begin
            if (cmd.capture) begin
               num_ff <= {1'b0, req_duration_ms} + NUM_W'(MS_PER_TICK - 1);
            end else if (cmd.div_step && !div_done) begin
               if (step_ff == 2'd0) begin
                  acc_ff <= PROD_W'(prod);
               end else begin
                  acc_ff <= acc_ff + {prod, HALF'(0)};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset || cmd.capture) begin
               step_ff <= '0;
            end else if (cmd.div_step && !div_done) begin
               step_ff <= step_ff + 2'd1;
            end
         end

         assign ticks_full = NUM_W'(acc_ff >> (NUM_W + L));
      end
   endgenerate

   assign ticks_sat = (ticks_full > (DUR_W + 1)'(TICK_LIMIT)) ? TICK_LIMIT
                                                             : ticks_full[TICK_W-1:0];

   // Walk stage: decrement the count read in the previous cycle
   assign rd_more = (rd_ptr_ff < CW'(NUM_TIMERS));
   assign p1_run  = run_ff[p1_idx_ff];
   assign dec     = rem_q_ff - TICK_W'(1);
   assign fire    = p1_vld_ff && p1_run && (dec == '0);

   always_comb begin
      mem_we   = 1'b0;
      mem_addr = p1_idx_ff;
      mem_data = dec;
      if (cmd.load) begin
         mem_we   = 1'b1;
         mem_addr = idx_ff[IW-1:0];
         mem_data = ticks_sat;
      end else if (p1_vld_ff && p1_run) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rem_mem[mem_addr] <= mem_data;
      end
      rem_q_ff <= rem_mem[rd_ptr_ff[IW-1:0]];
   end

   always_comb begin
      run_in = run_ff;
      if (cmd.load) begin
         run_in[idx_ff[IW-1:0]] = 1'b1;
      end
      if (cmd.respond && idx_ok_ff && (cmd_ff == CMD_STOP)) begin
         run_in[idx_ff[IW-1:0]] = 1'b0;
      end
      if (fire) begin
         run_in[p1_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         tick_en_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         if (cmd.load) begin
            tick_en_ff <= 1'b1;
         end else if (cmd.tick_finish && !any_acc_ff) begin
            tick_en_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         rd_ptr_ff   <= '0;
         p1_vld_ff   <= 1'b0;
         any_acc_ff  <= 1'b0;
         fire_cnt_ff <= '0;
         emit_ptr_ff <= '0;
      end else begin
         p1_vld_ff <= cmd.walk && rd_more;
         if (cmd.walk && rd_more) begin
            rd_ptr_ff <= rd_ptr_ff + CW'(1);
         end
         if (p1_vld_ff && p1_run && !fire) begin
            any_acc_ff <= 1'b1;
         end
         if (fire && (fire_cnt_ff < FIRE_CNT_W'(MAX_RESULTS))) begin
            fire_cnt_ff <= fire_cnt_ff + FIRE_CNT_W'(1);
         end
         if (cmd.emit) begin
            emit_ptr_ff <= emit_ptr_ff + FIRE_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= rd_ptr_ff[IW-1:0];
      if (fire && (fire_cnt_ff < FIRE_CNT_W'(MAX_RESULTS))) begin
         fire_list_ff[fire_cnt_ff[FIRE_PTR_W-1:0]] <= IDX_W'(p1_idx_ff);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond || cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_index_ff   <= idx_ff;
         rsp_expired_ff <= 1'b0;
         rsp_running_ff <= idx_ok_ff && (cmd_ff != CMD_STOP) && run_ff[idx_ff[IW-1:0]];
         rsp_active_ff  <= tick_en_ff;
         rsp_last_ff    <= 1'b1;
      end else if (cmd.emit) begin
         rsp_running_ff <= 1'b0;
         rsp_active_ff  <= tick_en_ff;
         rsp_last_ff    <= status.emit_last;
         if (fire_cnt_ff == '0) begin
            rsp_index_ff   <= '0;
            rsp_expired_ff <= 1'b0;
         end else begin
            rsp_index_ff   <= fire_list_ff[emit_ptr_ff[FIRE_PTR_W-1:0]];
            rsp_expired_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_expired      = rsp_expired_ff;
   assign rsp_running      = rsp_running_ff;
   assign rsp_any_active   = rsp_active_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: rtl/software_timer_bank_top.sv
// Top level of the one-shot timer bank: controller plus datapath.
// Depends on stb_pkg, stb_ctrl and stb_datapath.
`timescale 1ns / 1ps
//
// Usage
//   Request channel: drive req_command, req_timer_index and req_duration_ms
//   with start high; the request is taken at the edge where start is high and
//   busy is low. Commands: start (load a timer), stop, query, tick.
//   Result channel: each result shows for exactly one cycle with rsp_valid
//   high. The receiver cannot stall, so results are never held or dropped;
//   rsp_last marks the final result of a request.
//   Steps while busy is high after the request is taken:
//     stop, query, ignored start : respond, result in the following cycle
//     start, MS_PER_TICK a power of two : shift-and-round of the duration
//     start, other MS_PER_TICK : reciprocal multiply, two partial products
//     tick : walk the count store, then one result per
//            reported expiry (one status result when none expire)
//   The tick walk is bounded by the single read port of the count store, which
//   visits one timer per cycle. A new request may be taken in the same cycle
//   that the last result of the previous one is shown.
//   Reset idles every timer and clears the tick enable; no clearing pass is
//   needed since a count is only used while its running flag is set.
//

module software_timer_bank_top
   import stb_pkg::*;
#(
   parameter int NUM_TIMERS  = 8,
   parameter int MS_PER_TICK = 1
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [IDX_W-1:0]   req_timer_index,
   input  logic [DUR_W-1:0]   req_duration_ms,
   output logic               rsp_valid,
   output logic [IDX_W-1:0]   rsp_result_index,
   output logic               rsp_expired,
   output logic               rsp_running,
   output logic               rsp_any_active,
   output logic               rsp_last
);

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   // Sequence each request through its states
   stb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (ctrl_status),
      .cmd    (ctrl_cmd)
   );

   // Hold the timers and build the results
   stb_datapath #(
      .NUM_TIMERS  (NUM_TIMERS),
      .MS_PER_TICK (MS_PER_TICK)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_timer_index  (req_timer_index),
      .req_duration_ms  (req_duration_ms),
      .cmd              (ctrl_cmd),
      .status           (ctrl_status),
      .rsp_valid        (rsp_valid),
      .rsp_result_index (rsp_result_index),
      .rsp_expired      (rsp_expired),
      .rsp_running      (rsp_running),
      .rsp_any_active   (rsp_any_active),
      .rsp_last         (rsp_last)
   );

endmodule

// File: rtl/stb_checker.sv
// Port-level checks for the timer bank, bound to software_timer_bank_top.
// Depends on stb_pkg for field widths.
`timescale 1ns / 1ps

module stb_checker
   import stb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [IDX_W-1:0] rsp_result_index,
   input logic             rsp_expired,
   input logic             rsp_running,
   input logic             rsp_any_active,
   input logic             rsp_last
);

   // A taken request makes busy high in the cycle after it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after a request was taken");

   // An expiry names a known timer and reports it idle
   a_expired_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expired) |-> (!rsp_running && !$isunknown(rsp_result_index)))
      else $error("expiry reported with running set or unknown index");

   // A running timer implies the tick enable is set
   a_running_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_running) |-> rsp_any_active)
      else $error("running timer with tick enable clear");

   // The final result of a request is followed by a gap
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result right after the final one");

   // Multi-result bursts are back to back expiries
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_valid && rsp_expired))
      else $error("expiry burst broken");

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_result_index (rsp_result_index),
   .rsp_expired      (rsp_expired),
   .rsp_running      (rsp_running),
   .rsp_any_active   (rsp_any_active),
   .rsp_last         (rsp_last)
);
